### rtl/core/ptl3d_pkg.sv
`default_nettype none
package ptl3d_pkg;

  localparam int OUT_W     = 32;
  localparam int QW        = 2 * OUT_W;
  localparam int IN_FIELDS = 9;
  localparam int OUT_BYTES = (OUT_W + 2 + 7) / 8;

  typedef logic [OUT_W-1:0] dist_t;

endpackage
`default_nettype wire

### rtl/core/ptl3d_front.sv
`default_nettype none
module ptl3d_front #(
  parameter int CB  = 32,
  parameter int NW  = 136,
  parameter int DNW = 68
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [9*CB-1:0]      in_coords,
  output      logic                 f_valid,
  output      logic [NW-1:0]        f_num,
  output      logic [DNW-1:0]       f_den,
  output      logic                 f_deg
);
  import ptl3d_pkg::*;

  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;
  localparam int KW = XW;
  localparam int KL = (KW + 1) / 2;
  localparam int KH = KW - KL;

  logic [6:1] v_r;

  logic signed [CB-1:0] co [IN_FIELDS];

  logic signed [DW-1:0] d_nxt [3];
  logic signed [DW-1:0] c_nxt [3];
  logic signed [DW-1:0] d_r   [3];
  logic signed [DW-1:0] c_r   [3];
  logic                 deg_nxt;
  logic [6:1]           deg_r;

  logic signed [PW-1:0] pa_r [3];
  logic signed [PW-1:0] pb_r [3];
  logic signed [PW-1:0] sq_r [3];

  logic signed [XW-1:0] x_nxt [3];
  logic [KW-1:0]        k_r   [3];
  logic [DNW-1:0]       den3_r;
  logic [DNW-1:0]       den4_r;
  logic [DNW-1:0]       den5_r;
  logic [DNW-1:0]       den6_r;

  logic [2*KH-1:0]      hh_r [3];
  logic [KH+KL-1:0]     hl_r [3];
  logic [2*KL-1:0]      ll_r [3];
  logic [NW-1:0]        ks_r [3];
  logic [NW-1:0]        num_r;

  always_comb begin
    for (int i = 0; i < IN_FIELDS; i++) begin
      co[i] = in_coords[i*CB +: CB];
    end
    for (int i = 0; i < 3; i++) begin
      d_nxt[i] = DW'(co[3+i]) - DW'(co[i]);
      c_nxt[i] = DW'(co[i]) - DW'(co[6+i]);
    end
    deg_nxt = (co[0] == co[3]) && (co[1] == co[4]) && (co[2] == co[5]);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x_nxt[i] = XW'(pa_r[i]) - XW'(pb_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r      <= d_nxt;
      c_r      <= c_nxt;
      deg_r    <= {deg_r[5:1], deg_nxt};
      // cross product terms of c x d and squared direction
      pa_r[0] <= c_r[1] * d_r[2];
      pb_r[0] <= c_r[2] * d_r[1];
      pa_r[1] <= c_r[2] * d_r[0];
      pb_r[1] <= c_r[0] * d_r[2];
      pa_r[2] <= c_r[0] * d_r[1];
      pb_r[2] <= c_r[1] * d_r[0];
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= d_r[i] * d_r[i];
        k_r[i]  <= x_nxt[i][XW-1] ? KW'(-x_nxt[i]) : KW'(x_nxt[i]);
        hh_r[i] <= k_r[i][KW-1:KL] * k_r[i][KW-1:KL];
        hl_r[i] <= k_r[i][KW-1:KL] * k_r[i][KL-1:0];
        ll_r[i] <= k_r[i][KL-1:0] * k_r[i][KL-1:0];
        ks_r[i] <= (NW'(hh_r[i]) << (2 * KL)) + (NW'(hl_r[i]) << (KL + 1))
                 + NW'(ll_r[i]);
      end
      den3_r <= DNW'($unsigned(sq_r[0])) + DNW'($unsigned(sq_r[1]))
              + DNW'($unsigned(sq_r[2]));
      den4_r <= den3_r;
      den5_r <= den4_r;
      den6_r <= den5_r;
      num_r  <= ks_r[0] + ks_r[1] + ks_r[2];
    end
  end

  assign f_valid = v_r[6];
  assign f_num   = num_r;
  assign f_den   = den6_r;
  assign f_deg   = deg_r[6];

endmodule
`default_nettype wire

### rtl/core/ptl3d_queue.sv
`default_nettype none
module ptl3d_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output      logic         full,
  input  wire logic         pop,
  output      logic         head_valid,
  output      logic [W-1:0] head_data
);
  import ptl3d_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW:0]   count_r;
  logic          do_push;
  logic          do_pop;

  assign full       = (count_r == (AW+1)'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

### rtl/core/ptl3d_back.sv
`default_nettype none
module ptl3d_back #(
  parameter int NW  = 136,
  parameter int DNW = 68
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire logic [NW-1:0]    q_num,
  input  wire logic [DNW-1:0]   q_den,
  input  wire logic             q_deg,
  output      logic             q_pop,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      ptl3d_pkg::dist_t out_distance,
  output      logic             out_degenerate,
  output      logic             out_saturated
);
  import ptl3d_pkg::*;

  localparam int HW  = NW - QW;
  localparam int SRW = OUT_W + 2;

  logic en;

  logic           dv_v_r   [QW+1];
  logic [DNW-1:0] dv_rem_r [QW+1];
  logic [QW-1:0]  dv_low_r [QW+1];
  logic [QW-1:0]  dv_q_r   [QW+1];
  logic [DNW-1:0] dv_den_r [QW+1];
  logic           dv_deg_r [QW+1];
  logic           dv_sat_r [QW+1];

  logic           sq_v_r    [OUT_W];
  logic [SRW-1:0] sq_rem_r  [OUT_W];
  logic [OUT_W-1:0] sq_root_r [OUT_W];
  logic [QW-1:0]  sq_bits_r [OUT_W];
  logic           sq_deg_r  [OUT_W];
  logic           sq_sat_r  [OUT_W];

  logic           out_valid_r;
  dist_t          out_dist_r;
  logic           out_deg_r;
  logic           out_sat_r;

  logic [HW-1:0]  num_hi;
  logic           sat_nxt;

  assign en     = !out_valid_r || out_ready;
  assign q_pop  = en;
  assign num_hi = q_num[NW-1:QW];
  assign sat_nxt = ({{DNW{1'b0}}, num_hi} >= {{HW{1'b0}}, q_den});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0] <= DNW'(num_hi);
      dv_low_r[0] <= q_num[QW-1:0];
      dv_q_r[0]   <= '0;
      dv_den_r[0] <= q_den;
      dv_deg_r[0] <= q_deg;
      dv_sat_r[0] <= sat_nxt;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [DNW:0]   t;
    logic           ge;
    logic [DNW-1:0] rem_nxt;

    always_comb begin
      t       = {dv_rem_r[k-1], dv_low_r[k-1][QW-1]};
      ge      = (t >= {1'b0, dv_den_r[k-1]});
      rem_nxt = ge ? DNW'(t - {1'b0, dv_den_r[k-1]}) : DNW'(t);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k] <= 1'b0;
      end else if (en) begin
        dv_v_r[k] <= dv_v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[k] <= rem_nxt;
        dv_low_r[k] <= {dv_low_r[k-1][QW-2:0], 1'b0};
        dv_q_r[k]   <= {dv_q_r[k-1][QW-2:0], ge};
        dv_den_r[k] <= dv_den_r[k-1];
        dv_deg_r[k] <= dv_deg_r[k-1];
        dv_sat_r[k] <= dv_sat_r[k-1];
      end
    end
  end

  for (genvar j = 0; j < OUT_W; j++) begin : g_sqrt
    logic             pv;
    logic [SRW-1:0]   prem;
    logic [OUT_W-1:0] proot;
    logic [QW-1:0]    pbits;
    logic             pdeg;
    logic             psat;
    logic [SRW+1:0]   v;
    logic [SRW+1:0]   trial;
    logic             ge;

    if (j == 0) begin : g_first
      assign pv    = dv_v_r[QW];
      assign prem  = '0;
      assign proot = '0;
      assign pbits = dv_q_r[QW];
      assign pdeg  = dv_deg_r[QW];
      assign psat  = dv_sat_r[QW];
    end else begin : g_next
      assign pv    = sq_v_r[j-1];
      assign prem  = sq_rem_r[j-1];
      assign proot = sq_root_r[j-1];
      assign pbits = sq_bits_r[j-1];
      assign pdeg  = sq_deg_r[j-1];
      assign psat  = sq_sat_r[j-1];
    end

    always_comb begin
      v     = {prem, pbits[QW-1:QW-2]};
      trial = (SRW+2)'({proot, 2'b01});
      ge    = (v >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j] <= 1'b0;
      end else if (en) begin
        sq_v_r[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[j]  <= ge ? SRW'(v - trial) : SRW'(v);
        sq_root_r[j] <= {proot[OUT_W-2:0], ge};
        sq_bits_r[j] <= {pbits[QW-3:0], 2'b00};
        sq_deg_r[j]  <= pdeg;
        sq_sat_r[j]  <= psat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sq_v_r[OUT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_deg_r <= sq_deg_r[OUT_W-1];
      out_sat_r <= !sq_deg_r[OUT_W-1] && sq_sat_r[OUT_W-1];
      if (sq_deg_r[OUT_W-1]) begin
        out_dist_r <= '0;
      end else if (sq_sat_r[OUT_W-1]) begin
        out_dist_r <= '1;
      end else begin
        out_dist_r <= sq_root_r[OUT_W-1];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_distance   = out_dist_r;
  assign out_degenerate = out_deg_r;
  assign out_saturated  = out_sat_r;

endmodule
`default_nettype wire

### rtl/core/point_to_line_distance_3d_unit.sv
// Perpendicular distance from a query point to the 3D line through two points.
// Input channel in_*: one item per handshake, nine signed coordinates in tdata.
// Output channel out_*: one item per input item, in input order.
// Throughput: one item per cycle while out_tready stays high.
// Path from the accepting edge to out_tvalid: 6 front stages
// (differences, cross products, squares, sums), the 4-entry queue,
// then a load stage and 64 divider stages (one quotient bit each),
// 32 square-root stages (one root bit each) and the output register.
// The front keeps taking items while the back stalls until the queue is full;
// in_tready then drops. A stalled out_tready freezes the back pipeline and
// holds the output item stable.
// Reset (rst_n low, synchronous) empties the pipeline and the queue.
// Coincident line points give distance 0 with degenerate set; a distance of
// 2^32 LSB or more gives all ones with saturated set.
`default_nettype none
module point_to_line_distance_3d_unit #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output      logic                                  in_tready,
  // line_a_x, line_a_y, line_a_z, line_b_x, line_b_y, line_b_z,
  // query_x, query_y, query_z
  input  wire logic [((9*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  output      logic                                  out_tvalid,
  input  wire logic                                  out_tready,
  // distance, degenerate, saturated
  output      logic [ptl3d_pkg::OUT_BYTES*8-1:0]     out_tdata
);
  import ptl3d_pkg::*;

  localparam int DW  = COORD_BITS + 1;
  localparam int KW  = 2 * DW + 1;
  localparam int NW  = 2 * KW + 2;
  localparam int DNW = 2 * DW + 2;
  localparam int QDW = NW + DNW + 1;

  logic            front_en;
  logic            f_valid;
  logic [NW-1:0]   f_num;
  logic [DNW-1:0]  f_den;
  logic            f_deg;
  logic            q_full;
  logic            q_pop;
  logic            q_valid;
  logic [QDW-1:0]  q_data;
  logic            b_valid;
  dist_t           b_dist;
  logic            b_deg;
  logic            b_sat;

  assign front_en  = !q_full;
  assign in_tready = front_en;

  ptl3d_front #(.CB(COORD_BITS), .NW(NW), .DNW(DNW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (front_en),
    .in_valid  (in_tvalid),
    .in_coords (in_tdata[9*COORD_BITS-1:0]),
    .f_valid   (f_valid),
    .f_num     (f_num),
    .f_den     (f_den),
    .f_deg     (f_deg)
  );

  ptl3d_queue #(.W(QDW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_valid),
    .push_data  ({f_deg, f_den, f_num}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_data)
  );

  ptl3d_back #(.NW(NW), .DNW(DNW)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_num          (q_data[NW-1:0]),
    .q_den          (q_data[NW+DNW-1:NW]),
    .q_deg          (q_data[QDW-1]),
    .q_pop          (q_pop),
    .out_valid      (b_valid),
    .out_ready      (out_tready),
    .out_distance   (b_dist),
    .out_degenerate (b_deg),
    .out_saturated  (b_sat)
  );

  assign out_tvalid = b_valid;
  assign out_tdata  = (OUT_BYTES*8)'({b_sat, b_deg, b_dist});

endmodule
`default_nettype wire

### sim/point_to_line_distance_3d_checker.sv
`timescale 1ns / 1ps
module point_to_line_distance_3d_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [287:0] in_tdata,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [39:0]  out_tdata,
  output int                fail_count,
  output int                pending
);
  import ptl3d_pkg::*;

  typedef struct packed {
    dist_t distance;
    logic  degenerate;
    logic  saturated;
  } dist_result_t;

  dist_result_t expected_q[$];

  function automatic logic signed [63:0] coord(input logic [287:0] d, input int idx);
    logic signed [31:0] c;
    c = d[idx*32 +: 32];
    return 64'(c);
  endfunction

  function automatic dist_result_t compute_distance(input logic [287:0] d);
    dist_result_t r;
    logic signed [63:0] dx, dy, dz, cx, cy, cz;
    logic signed [255:0] k0, k1, k2;
    logic [255:0] num, den, cand_sq;
    logic [63:0] root, cand;
    dx = coord(d, 3) - coord(d, 0);
    dy = coord(d, 4) - coord(d, 1);
    dz = coord(d, 5) - coord(d, 2);
    cx = coord(d, 0) - coord(d, 6);
    cy = coord(d, 1) - coord(d, 7);
    cz = coord(d, 2) - coord(d, 8);
    r = '0;
    if (dx == 0 && dy == 0 && dz == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    k0 = 256'(cy) * 256'(dz) - 256'(cz) * 256'(dy);
    k1 = 256'(cz) * 256'(dx) - 256'(cx) * 256'(dz);
    k2 = 256'(cx) * 256'(dy) - 256'(cy) * 256'(dx);
    num = k0 * k0 + k1 * k1 + k2 * k2;
    den = 256'(dx) * 256'(dx) + 256'(dy) * 256'(dy) + 256'(dz) * 256'(dz);
    if ((den << 64) <= num) begin
      r.distance  = '1;
      r.saturated = 1'b1;
      return r;
    end
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      cand_sq = 256'(cand) * 256'(cand);
      if (cand_sq * den <= num) root = cand;
    end
    r.distance = root[31:0];
    return r;
  endfunction

  initial fail_count = 0;
  initial pending = 0;

  always @(posedge clk) begin
    dist_result_t got, exp_r;
    if (rst_n && in_tvalid && in_tready) expected_q.push_back(compute_distance(in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      got.distance   = out_tdata[31:0];
      got.degenerate = out_tdata[32];
      got.saturated  = out_tdata[33];
      if (expected_q.size() == 0) begin
        $error("unexpected item: distance %h", got.distance);
        fail_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.distance !== exp_r.distance) begin
          $error("distance: expected %h actual %h", exp_r.distance, got.distance);
          fail_count++;
        end
        if (got.degenerate !== exp_r.degenerate) begin
          $error("degenerate: expected %b actual %b", exp_r.degenerate, got.degenerate);
          fail_count++;
        end
        if (got.saturated !== exp_r.saturated) begin
          $error("saturated: expected %b actual %b", exp_r.saturated, got.saturated);
          fail_count++;
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

### sim/point_to_line_distance_3d_unit_test.sv
`timescale 1ns / 1ps
module point_to_line_distance_3d_unit_test;
  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [287:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [39:0]  out_tdata;
  int           fail_count;
  int           pending;
  bit           quiet = 0;
  bit           hold_off = 0;
  bit           stim_done = 0;
  int           sent = 0;

  point_to_line_distance_3d_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  point_to_line_distance_3d_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic logic [31:0] pick_coord(input int mode);
    case (mode)
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(int'($urandom_range(0, 2000)) - 1000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [287:0] random_item();
    logic [287:0] d;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      if (mode < 2) d[i*32 +: 32] = pick_coord($urandom_range(0, 3));
      else if (mode < 5) d[i*32 +: 32] = pick_coord(2);
      else d[i*32 +: 32] = $urandom();
    end
    if ($urandom_range(0, 19) == 0) d[191:96] = d[95:0];
    else if ($urandom_range(0, 19) == 0) d[287:192] = d[95:0];
    return d;
  endfunction

  task automatic send(input logic [287:0] d);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [287:0] splat(input logic [31:0] a, b, q);
    return {q, q, q, b, b, b, a, a, a};
  endfunction

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    send(splat(32'h0001_0000, 32'h0001_0000, 32'h0));
    send(splat(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    send('0);
    send('1);
    send({32'h0, 32'h0005_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 96'h0});
    send({32'h0, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0, 32'h0001_0000, 96'h0});
    send({32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0001, 32'h8000_0000, 32'h8000_0000, {3{32'h7fff_ffff}}});
    send({32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
          32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 96'h0});
    send({32'h0, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0, 32'h8000_0000,
          32'h0, 32'h0, 32'h7fff_ffff});
    send({32'h0, 32'h0000_0001, 32'h0, 32'h0, 32'h0, 32'h0000_0001, 96'h0});
    send({32'h0, 32'h0000_0001, 32'h0, 32'h0, 32'h0, 32'h0000_0002, 96'h0});
    send({{3{32'h5555_5555}}, {3{32'haaaa_aaaa}}, 96'h0});
    send({{3{32'haaaa_aaaa}}, {3{32'h5555_5555}}, 96'h0});
    send({96'h0, 96'h0, {32'h0, 32'h0, 32'h0001_0000}});
    for (int i = 0; i < 1000; i++) begin
      if (i == 200) hold_off = 1;
      if (i == 800) quiet = 1;
      send(random_item());
    end
    in_tvalid <= 0;
    stim_done = 1;
  end

  initial begin
    wait (hold_off);
    @(negedge clk);
    repeat (300) @(negedge clk);
    hold_off = 0;
  end

  initial begin
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_off) out_tready <= 0;
      else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        if (!hold_off) out_tready <= 1;
      end else out_tready <= 1;
    end
  end

  initial begin
    wait (stim_done);
    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
